FILE: sv/tcc_pkg.sv
// Shared constants, codes and types of the text console cursor and cell engine.
`default_nettype none
package tcc_pkg;

	// Grid geometry
	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 64;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int MEM_DEPTH   = 1 << ADDR_W;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BS    = 8'h08;

	// Opcodes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOINIT  = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_ENABLED     = 3'd0;
	localparam logic [2:0] REG_COLUMN_CNT  = 3'd1;
	localparam logic [2:0] REG_ROW_CNT     = 3'd2;
	localparam logic [2:0] REG_GLYPH_FIRST = 3'd3;
	localparam logic [2:0] REG_GLYPH_TOTAL = 3'd4;
	localparam logic [2:0] REG_VISIBLE     = 3'd5;

	typedef struct packed {
		logic       enabled;
		logic [7:0] column_count;
		logic [6:0] row_count;
		logic [7:0] glyph_first;
		logic [8:0] glyph_total;
		logic       visible;
	} cfg_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic take;
		logic decode;
		logic init_wr;
		logic sc_wr;
		logic blank;
		logic put;
		logic rd_cap;
		logic out_load;
	} ctl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic dec_clear;
		logic dec_scroll;
		logic dec_put;
		logic dec_read;
		logic copy_needed;
		logic col_last;
		logic row_last;
		logic init_last;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: sv/tcc_regs.sv
// APB-style configuration register file of the console engine.
`default_nettype none
module tcc_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output tcc_pkg::cfg_t     cfg
);

	tcc_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled      <= 1'b1;
			cfg_q.column_count <= 8'd80;
			cfg_q.row_count    <= 7'd30;
			cfg_q.glyph_first  <= 8'd32;
			cfg_q.glyph_total  <= 9'd95;
			cfg_q.visible      <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				tcc_pkg::REG_ENABLED:     cfg_q.enabled      <= pwdata[0];
				tcc_pkg::REG_COLUMN_CNT:  cfg_q.column_count <= pwdata[7:0];
				tcc_pkg::REG_ROW_CNT:     cfg_q.row_count    <= pwdata[6:0];
				tcc_pkg::REG_GLYPH_FIRST: cfg_q.glyph_first  <= pwdata[7:0];
				tcc_pkg::REG_GLYPH_TOTAL: cfg_q.glyph_total  <= pwdata[8:0];
				tcc_pkg::REG_VISIBLE:     cfg_q.visible      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		case (idx)
			tcc_pkg::REG_ENABLED:     prdata = {31'd0, cfg_q.enabled};
			tcc_pkg::REG_COLUMN_CNT:  prdata = {24'd0, cfg_q.column_count};
			tcc_pkg::REG_ROW_CNT:     prdata = {25'd0, cfg_q.row_count};
			tcc_pkg::REG_GLYPH_FIRST: prdata = {24'd0, cfg_q.glyph_first};
			tcc_pkg::REG_GLYPH_TOTAL: prdata = {23'd0, cfg_q.glyph_total};
			tcc_pkg::REG_VISIBLE:     prdata = {31'd0, cfg_q.visible};
			default:                  prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/tcc_ctrl.sv
// Sequencer of the console engine: item intake, memory walks and result hand-off.
`default_nettype none
module tcc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire tcc_pkg::dp_status_t sts,
	output tcc_pkg::ctl_cmd_t        cmd
);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_SC_RD  = 4'd3;
	localparam logic [3:0] S_SC_WR  = 4'd4;
	localparam logic [3:0] S_BLANK  = 4'd5;
	localparam logic [3:0] S_PUT    = 4'd6;
	localparam logic [3:0] S_RDCAP  = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       put_pend_q;

	assign cmd_stall = (state_q != S_IDLE);

	// Next state and command decode
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_valid) begin
					cmd.take  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.dec_clear)
					state_nxt = S_BLANK;
				else if (sts.dec_scroll)
					state_nxt = sts.copy_needed ? S_SC_RD : S_BLANK;
				else if (sts.dec_put)
					state_nxt = S_PUT;
				else if (sts.dec_read)
					state_nxt = S_RDCAP;
				else
					state_nxt = S_DONE;
			end
			S_SC_RD: state_nxt = S_SC_WR;
			S_SC_WR: begin
				cmd.sc_wr = 1'b1;
				state_nxt = (sts.col_last && sts.row_last) ? S_BLANK : S_SC_RD;
			end
			S_BLANK: begin
				cmd.blank = 1'b1;
				if (sts.col_last && sts.row_last)
					state_nxt = put_pend_q ? S_PUT : S_DONE;
			end
			S_PUT: begin
				cmd.put   = 1'b1;
				state_nxt = S_DONE;
			end
			S_RDCAP: begin
				cmd.rd_cap = 1'b1;
				state_nxt  = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// State register; a put pending behind a scroll is remembered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			put_pend_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.decode) put_pend_q <= sts.dec_put;
		end
	end

endmodule
`default_nettype wire

FILE: sv/tcc_dp.sv
// Datapath of the console engine: cell memory, cursor, counters, result register.
`default_nettype none
module tcc_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcc_pkg::cfg_t     cfg,
	input  wire tcc_pkg::ctl_cmd_t cmd,
	output tcc_pkg::dp_status_t sts,
	input  wire logic [1:0]    opcode,
	input  wire logic [7:0]    char_code,
	input  wire logic [6:0]    read_column,
	input  wire logic [5:0]    read_row,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output logic [1:0]         status,
	output logic               drew,
	output logic [6:0]         draw_column,
	output logic [5:0]         draw_row,
	output logic [7:0]         glyph_code,
	output logic               scrolled,
	output logic [7:0]         cursor_column,
	output logic [5:0]         cursor_row,
	output logic [7:0]         cell_data,
	output logic [31:0]        char_total,
	output logic [31:0]        scroll_total
);

	localparam int CW = tcc_pkg::COL_W;
	localparam int RW = tcc_pkg::ROW_W;
	localparam int AW = tcc_pkg::ADDR_W;

	// Cell memory
	logic [7:0]    mem [tcc_pkg::MEM_DEPTH];
	logic [7:0]    rdata_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [7:0]    wdata;

	// Latched item
	logic [1:0]    op_q;
	logic [7:0]    ch_q;
	logic [CW-1:0] rc_q;
	logic [RW-1:0] rr_q;

	// Architectural state
	logic [7:0]    cur_col_q;
	logic [RW-1:0] cur_line_q;
	logic [31:0]   chars_q;
	logic [31:0]   scrolls_q;
	logic [AW-1:0] init_addr_q;

	// Walk counters and put target
	logic [CW-1:0] w_col_q;
	logic [RW-1:0] w_row_q;
	logic [CW-1:0] put_col_q;
	logic [RW-1:0] put_row_q;

	// Work result
	logic [1:0]    res_status_q;
	logic          res_drew_q;
	logic [CW-1:0] res_dcol_q;
	logic [RW-1:0] res_drow_q;
	logic [7:0]    res_glyph_q;
	logic          res_scrolled_q;
	logic [7:0]    res_data_q;

	// Output register
	logic          out_valid_q;
	logic [1:0]    o_status_q;
	logic          o_drew_q;
	logic [CW-1:0] o_dcol_q;
	logic [RW-1:0] o_drow_q;
	logic [7:0]    o_glyph_q;
	logic          o_scrolled_q;
	logic [7:0]    o_col_q;
	logic [RW-1:0] o_row_q;
	logic [7:0]    o_data_q;
	logic [31:0]   o_chars_q;
	logic [31:0]   o_scrolls_q;

	// Effective grid size
	logic [7:0]    cols;
	logic [6:0]    rows;
	logic [7:0]    cols_m1;
	logic [6:0]    rows_m1;

	// Decode terms
	logic          en;
	logic          is_put, is_char, is_lf, is_cr, is_bs;
	logic [RW-1:0] line_eff;
	logic          at_last;
	logic          wrap;
	logic          do_lf;
	logic          scroll;
	logic [RW-1:0] new_line;
	logic [CW-1:0] put_col;
	logic [7:0]    new_col;
	logic          read_ok;
	logic          covered;
	logic [9:0]    glyph_end;

	always_comb begin
		if (cfg.column_count == 8'd0)
			cols = 8'd1;
		else if (cfg.column_count > 8'(tcc_pkg::MAX_COLUMNS))
			cols = 8'(tcc_pkg::MAX_COLUMNS);
		else
			cols = cfg.column_count;
		if (cfg.row_count == 7'd0)
			rows = 7'd1;
		else if (cfg.row_count > 7'(tcc_pkg::MAX_ROWS))
			rows = 7'(tcc_pkg::MAX_ROWS);
		else
			rows = cfg.row_count;
	end

	assign cols_m1 = cols - 8'd1;
	assign rows_m1 = rows - 7'd1;

	// Item decode against the current cursor
	assign en      = cfg.enabled;
	assign is_put  = en && (op_q == tcc_pkg::OP_PUT);
	assign is_lf   = (ch_q == tcc_pkg::CH_LF);
	assign is_cr   = (ch_q == tcc_pkg::CH_CR);
	assign is_bs   = (ch_q == tcc_pkg::CH_BS);
	assign is_char = !is_lf && !is_cr && !is_bs;

	assign line_eff = ({1'b0, cur_line_q} > rows_m1) ? rows_m1[RW-1:0] : cur_line_q;
	assign at_last  = ({1'b0, line_eff} == rows_m1);
	assign wrap     = is_char && (cur_col_q >= cols);
	assign do_lf    = is_lf || wrap;
	assign scroll   = is_put && do_lf && at_last;
	assign new_line = (do_lf && !at_last) ? line_eff + RW'(1) : line_eff;
	assign put_col  = wrap ? '0 : cur_col_q[CW-1:0];

	always_comb begin
		if (is_lf || is_cr)
			new_col = 8'd0;
		else if (is_bs)
			new_col = (cur_col_q != 8'd0) ? cur_col_q - 8'd1 : cur_col_q;
		else
			new_col = {1'b0, put_col} + 8'd1;
	end

	assign read_ok   = ({1'b0, rc_q} < cols) && ({1'b0, rr_q} < rows);
	assign glyph_end = {2'b00, cfg.glyph_first} + {1'b0, cfg.glyph_total};
	assign covered   = (ch_q >= cfg.glyph_first) && ({2'b00, ch_q} < glyph_end);

	// Status to the controller
	assign sts.dec_clear   = en && (op_q == tcc_pkg::OP_CLEAR);
	assign sts.dec_scroll  = scroll;
	assign sts.dec_put     = is_put && is_char;
	assign sts.dec_read    = en && (op_q == tcc_pkg::OP_READ) && read_ok;
	assign sts.copy_needed = (rows_m1 != 7'd0);
	assign sts.col_last    = ({1'b0, w_col_q} == cols_m1);
	assign sts.row_last    = ({1'b0, w_row_q} == rows_m1);
	assign sts.init_last   = (init_addr_q == AW'(tcc_pkg::MEM_DEPTH - 1));
	assign sts.out_free    = !out_valid_q || !rsp_stall;

	// Memory port selection
	always_comb begin
		we    = cmd.init_wr || cmd.sc_wr || cmd.blank || cmd.put;
		wdata = tcc_pkg::CH_SPACE;
		waddr = {w_row_q, w_col_q};
		if (cmd.init_wr) begin
			waddr = init_addr_q;
		end else if (cmd.sc_wr) begin
			waddr = {w_row_q - RW'(1), w_col_q};
			wdata = rdata_q;
		end else if (cmd.put) begin
			waddr = {put_row_q, put_col_q};
			wdata = ch_q;
		end
	end

	assign raddr = cmd.decode ? {rr_q, rc_q} : {w_row_q, w_col_q};

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// Cursor, counters, clearing-pass address, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= 8'd0;
			cur_line_q  <= '0;
			chars_q     <= 32'd0;
			scrolls_q   <= 32'd0;
			init_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_wr) init_addr_q <= init_addr_q + AW'(1);
			if (cmd.decode) begin
				if (sts.dec_clear) begin
					cur_col_q  <= 8'd0;
					cur_line_q <= '0;
				end else if (is_put) begin
					cur_col_q  <= new_col;
					cur_line_q <= new_line;
					if (is_char) chars_q <= chars_q + 32'd1;
					if (scroll) scrolls_q <= scrolls_q + 32'd1;
				end
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Item latch, walk counters, work result, output payload
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= opcode;
			ch_q <= char_code;
			rc_q <= read_column;
			rr_q <= read_row;
		end
		if (cmd.decode) begin
			w_col_q        <= '0;
			w_row_q        <= (!sts.dec_clear && sts.copy_needed) ? RW'(1) : '0;
			put_col_q      <= put_col;
			put_row_q      <= new_line;
			res_drew_q     <= sts.dec_put && cfg.visible;
			res_dcol_q     <= (sts.dec_put && cfg.visible) ? put_col : '0;
			res_drow_q     <= (sts.dec_put && cfg.visible) ? new_line : '0;
			res_glyph_q    <= (sts.dec_put && cfg.visible) ?
				(covered ? ch_q : tcc_pkg::CH_QMARK) : 8'd0;
			res_scrolled_q <= scroll;
			res_data_q     <= 8'd0;
			if (!en)
				res_status_q <= tcc_pkg::ST_NOINIT;
			else if ((op_q == tcc_pkg::OP_READ) && !read_ok)
				res_status_q <= tcc_pkg::ST_OUTSIDE;
			else
				res_status_q <= tcc_pkg::ST_OK;
		end else if (cmd.sc_wr || cmd.blank) begin
			if (sts.col_last) begin
				w_col_q <= '0;
				if (!sts.row_last) w_row_q <= w_row_q + RW'(1);
			end else begin
				w_col_q <= w_col_q + CW'(1);
			end
		end
		if (cmd.rd_cap) res_data_q <= rdata_q;
		if (cmd.out_load) begin
			o_status_q   <= res_status_q;
			o_drew_q     <= res_drew_q;
			o_dcol_q     <= res_dcol_q;
			o_drow_q     <= res_drow_q;
			o_glyph_q    <= res_glyph_q;
			o_scrolled_q <= res_scrolled_q;
			o_col_q      <= cur_col_q;
			o_row_q      <= cur_line_q;
			o_data_q     <= res_data_q;
			o_chars_q    <= chars_q;
			o_scrolls_q  <= scrolls_q;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign status        = o_status_q;
	assign drew          = o_drew_q;
	assign draw_column   = o_dcol_q;
	assign draw_row      = o_drow_q;
	assign glyph_code    = o_glyph_q;
	assign scrolled      = o_scrolled_q;
	assign cursor_column = o_col_q;
	assign cursor_row    = o_row_q;
	assign cell_data     = o_data_q;
	assign char_total    = o_chars_q;
	assign scroll_total  = o_scrolls_q;

endmodule
`default_nettype wire

FILE: sv/text_console_cursor_and_cells_unit.sv
// Top level of the text console engine: registers, controller and datapath.
//
//  channel   direction  handshake              payload
//  command   in         cmd_valid / cmd_stall  opcode, char_code, read_column, read_row
//  response  out        rsp_valid / rsp_stall  status .. scroll_total (one per command)
//  config    in         APB psel/penable       paddr, pwdata, prdata, pready
//
// A carriage return, backspace, refused or unused-opcode command goes from decode
// straight to the done state, which loads the response register; a put passes
// through a cell write and a read through a memory capture on the way. A scroll
// copies every row but the first up by one and then blanks the last row, and a
// clear blanks every cell: the cell memory is walked one cell per step. After reset
// a clearing pass fills all 8192 cells with spaces while cmd_stall stays high. The
// next command is taken while a response still waits under rsp_stall; its own
// response then waits until that one leaves.
`default_nettype none
module text_console_cursor_and_cells_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  char_code,
	input  wire logic [6:0]  read_column,
	input  wire logic [5:0]  read_row,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [1:0]       status,
	output logic             drew,
	output logic [6:0]       draw_column,
	output logic [5:0]       draw_row,
	output logic [7:0]       glyph_code,
	output logic             scrolled,
	output logic [7:0]       cursor_column,
	output logic [5:0]       cursor_row,
	output logic [7:0]       cell_data,
	output logic [31:0]      char_total,
	output logic [31:0]      scroll_total,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	tcc_pkg::cfg_t       cfg;
	tcc_pkg::ctl_cmd_t   ctl_cmd;
	tcc_pkg::dp_status_t dp_sts;

	tcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (dp_sts),
		.cmd       (ctl_cmd)
	);

	tcc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (ctl_cmd),
		.sts           (dp_sts),
		.opcode        (opcode),
		.char_code     (char_code),
		.read_column   (read_column),
		.read_row      (read_row),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.drew          (drew),
		.draw_column   (draw_column),
		.draw_row      (draw_row),
		.glyph_code    (glyph_code),
		.scrolled      (scrolled),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row),
		.cell_data     (cell_data),
		.char_total    (char_total),
		.scroll_total  (scroll_total)
	);

	// One command in flight: a transfer closes the command side next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command taken while another is in work");

	// The response register is loaded only when it is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.out_load |-> (!rsp_valid || !rsp_stall))
		else $error("response overwritten before transfer");

	// Decode always follows the intake of a command
	a_decode_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.decode |-> $past(ctl_cmd.take))
		else $error("decode without a latched command");

endmodule
`default_nettype wire
